### src/bba_pkg.sv
// Shared types and codes of the bitmap block allocator.
package bba_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_INVALID   = 2'd2;

   // Width of one bitmap word and of its bit index.
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_ADD,
      ST_OFFSET,
      ST_RANGE,
      ST_ALIGN,
      ST_FREE,
      ST_DONE
   } state_type;

   // Write controls from the sequencer to the bitmap store.
   typedef struct packed {
      logic clear_all;
      logic set_bit;
      logic clear_bit;
   } map_ctrl_type;

endpackage

### src/bba_req_if.sv
// Request channel: opcode and the address of a block to free.
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] free_address;

   modport source (output valid, output opcode, output free_address, input ready);
   modport sink   (input valid, input opcode, input free_address, output ready);
endinterface

### src/bba_rsp_if.sv
// Result channel: status, block index and block address.
interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  block_index;
   logic [31:0] block_address;

   modport source (output valid, output status, output block_index, output block_address,
                   input ready);
   modport sink   (input valid, input status, input block_index, input block_address,
                   output ready);
endinterface

### src/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: sequencer, registers and output stage.
// Steps after acceptance: allocate scans the bitmap words, then forms and adds the block
// offset; free takes the offset, checks its range, aligns and frees the block.
// One item at a time: req ready only when idle, so the next item can be taken in the cycle
// after the result is registered, later while rsp ready is held low.
// Synchronous reset empties the bitmap, sets pool_base to zero and drops rsp valid.
module bitmap_block_allocator #(
   parameter int BLOCK_COUNT = 32,
   parameter int BLOCK_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   bba_req_if.sink     req_chan,
   bba_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);
   import bba_pkg::*;

   localparam int IDX_W       = $clog2(BLOCK_COUNT);
   localparam int MAP_WORDS   = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int POOL_SIZE   = BLOCK_COUNT * BLOCK_BYTES;
   localparam int OFS_W       = $clog2(POOL_SIZE);
   localparam int RECIP_SHIFT = OFS_W + $clog2(BLOCK_BYTES);
   localparam int PROD_W      = 2 * OFS_W + 1;
   localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + longint'(BLOCK_BYTES) - 1)
                                / longint'(BLOCK_BYTES);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

   state_type            state_ff, state_in;
   logic [31:0]          base_ff, base_in;
   logic [31:0]          addr_ff, addr_in;
   logic [31:0]          work_ff, work_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [4:0]           res_index_ff, res_index_in;
   logic [31:0]          res_address_ff, res_address_in;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           out_status_ff, out_status_in;
   logic [4:0]           out_index_ff, out_index_in;
   logic [31:0]          out_address_ff, out_address_in;

   logic                 accept;
   logic                 out_free;
   logic [31:0]          alu_a, alu_b, alu_result;
   logic                 alu_sub, alu_carry;
   map_ctrl_type         map_ctrl;
   logic [IDX_W-1:0]     map_index;
   logic                 has_free;
   logic [4:0]           free_bit;
   logic [IDX_W-1:0]     scan_idx;
   logic [PROD_W-1:0]    quot_prod;
   logic [IDX_W-1:0]     quotient;
   logic [31:0]          block_offset;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign scan_idx       = IDX_W'({word_ff, free_bit});

   // Block index of an in-range offset by multiplication with the rounded-up reciprocal.
   assign quot_prod = PROD_W'(work_ff[OFS_W-1:0]) * PROD_W'(RECIP);
   assign quotient  = IDX_W'(quot_prod >> RECIP_SHIFT);

   // Byte offset of the block that idx_ff names.
   assign block_offset = 32'(idx_ff) * 32'(BLOCK_BYTES);

   bba_alu u_alu (
      .operand_a (alu_a),
      .operand_b (alu_b),
      .subtract  (alu_sub),
      .result    (alu_result),
      .carry     (alu_carry)
   );

   bba_map #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .MAP_WORDS   (MAP_WORDS),
      .WORD_W      (WORD_W),
      .IDX_W       (IDX_W)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .rd_word  (word_ff),
      .ctrl     (map_ctrl),
      .wr_index (map_index),
      .has_free (has_free),
      .free_bit (free_bit)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.opcode)
                  OP_ALLOC: state_in = ST_SCAN;
                  OP_FREE:  state_in = (req_chan.free_address == 32'd0) ? ST_DONE : ST_OFFSET;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (has_free) begin
               state_in = ST_MUL;
            end else if (word_ff == LAST_WORD) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL:    state_in = ST_ADD;
         ST_ADD:    state_in = ST_DONE;
         ST_OFFSET: state_in = ST_RANGE;
         ST_RANGE:  state_in = alu_carry ? ST_DONE : ST_ALIGN;
         ST_ALIGN:  state_in = ST_FREE;
         ST_FREE:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and register updates for each state.
   always_comb begin
      base_in        = csr_write_en ? csr_write_data : base_ff;
      addr_in        = addr_ff;
      work_in        = work_ff;
      idx_in         = idx_ff;
      word_in        = word_ff;
      res_status_in  = res_status_ff;
      res_index_in   = res_index_ff;
      res_address_in = res_address_ff;
      alu_a          = work_ff;
      alu_b          = base_ff;
      alu_sub        = 1'b1;
      map_ctrl       = '0;
      map_index      = idx_ff;
      out_status_in  = out_status_ff;
      out_index_in   = out_index_ff;
      out_address_in = out_address_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in        = req_chan.free_address;
               word_in        = '0;
               res_index_in   = '0;
               res_address_in = '0;
               res_status_in  = STATUS_INVALID;
               if (req_chan.opcode == OP_CLEAR) begin
                  map_ctrl.clear_all = 1'b1;
                  res_status_in      = STATUS_DONE;
               end
            end
         end
         // One bitmap word examined per cycle.
         ST_SCAN: begin
            if (has_free) begin
               map_ctrl.set_bit = 1'b1;
               map_index        = scan_idx;
               idx_in           = scan_idx;
            end else if (word_ff == LAST_WORD) begin
               res_status_in  = STATUS_EXHAUSTED;
               res_index_in   = '0;
               res_address_in = '0;
            end else begin
               word_in = WORD_W'(word_ff + 1'b1);
            end
         end
         ST_MUL: begin
            work_in = block_offset;
         end
         ST_ADD: begin
            alu_a          = base_ff;
            alu_b          = work_ff;
            alu_sub        = 1'b0;
            res_status_in  = STATUS_DONE;
            res_index_in   = idx_ff[4:0];
            res_address_in = alu_result;
         end
         // Offset of the address from the pool base, modulo the address space.
         ST_OFFSET: begin
            alu_a   = addr_ff;
            alu_b   = base_ff;
            work_in = alu_result;
         end
         ST_RANGE: begin
            alu_a = work_ff;
            alu_b = 32'(POOL_SIZE);
            if (alu_carry) begin
               res_status_in  = STATUS_INVALID;
               res_index_in   = '0;
               res_address_in = '0;
            end else begin
               idx_in = quotient;
            end
         end
         // Start of the block that the quotient names, to test the offset against.
         ST_ALIGN: begin
            addr_in = block_offset;
         end
         // An offset past the block start means the address is not on a block boundary.
         ST_FREE: begin
            alu_a          = work_ff;
            alu_b          = addr_ff;
            res_index_in   = '0;
            res_address_in = '0;
            if (alu_result != 32'd0) begin
               res_status_in = STATUS_INVALID;
            end else begin
               map_ctrl.clear_bit = 1'b1;
               map_index          = idx_ff;
               res_status_in      = STATUS_DONE;
               res_index_in       = idx_ff[4:0];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_status_in  = res_status_ff;
               out_index_in   = res_index_ff;
               out_address_in = res_address_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      work_ff        <= work_in;
      idx_ff         <= idx_in;
      word_ff        <= word_in;
      res_status_ff  <= res_status_in;
      res_index_ff   <= res_index_in;
      res_address_ff <= res_address_in;
      out_status_ff  <= out_status_in;
      out_index_ff   <= out_index_in;
      out_address_ff <= out_address_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.block_index   = out_index_ff;
   assign rsp_chan.block_address = out_address_ff;
endmodule

### src/bba_alu.sv
// Shared 32-bit add and subtract unit used by the add, offset, range and free steps of the sequencer.
module bba_alu (
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   input  logic        subtract,
   output logic [31:0] result,
   output logic        carry
);
   import bba_pkg::*;

   logic [32:0] sum;

   // On a subtraction the carry is set when operand_a is not below operand_b.
   assign sum    = {1'b0, operand_a} + (subtract ? {1'b0, ~operand_b} : {1'b0, operand_b})
                   + {32'd0, subtract};
   assign result = sum[31:0];
   assign carry  = sum[32];
endmodule

### src/bba_map.sv
// In-use bitmap store with a lowest-free-bit search over one word.
module bba_map #(
   parameter int BLOCK_COUNT = 32,
   parameter int MAP_WORDS   = 1,
   parameter int WORD_W      = 1,
   parameter int IDX_W       = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WORD_W-1:0]     rd_word,
   input  bba_pkg::map_ctrl_type ctrl,
   input  logic [IDX_W-1:0]      wr_index,
   output logic                  has_free,
   output logic [4:0]            free_bit
);
   import bba_pkg::*;

   logic [WORD_BITS-1:0] words_ff [MAP_WORDS];
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] masked;
   logic [WORD_W-1:0]    wr_word;
   logic [BIT_W-1:0]     wr_bit;

   assign wr_word = WORD_W'(wr_index >> BIT_W);
   assign wr_bit  = wr_index[BIT_W-1:0];

   // Bitmap words: cleared by reset or clear all, otherwise one bit set or cleared.
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear_all) begin
         for (int w = 0; w < MAP_WORDS; w++) begin
            words_ff[w] <= '0;
         end
      end else if (ctrl.set_bit) begin
         words_ff[wr_word][wr_bit] <= 1'b1;
      end else if (ctrl.clear_bit) begin
         words_ff[wr_word][wr_bit] <= 1'b0;
      end
   end

   // Bits past the end of the pool count as in use.
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = ((int'(rd_word) * WORD_BITS + b) < BLOCK_COUNT);
      end
   end

   assign masked   = words_ff[rd_word] | ~valid_mask;
   assign has_free = ~&masked;

   // Priority encoder for the lowest clear bit.
   always_comb begin
      free_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!masked[b]) begin
            free_bit = BIT_W'(b);
         end
      end
   end
endmodule
